@@ rtl/flv_tag_framer_core_macros.svh @@
// Assertion macros used by the checker of the tag framer.
`ifndef FLV_TAG_FRAMER_CORE_MACROS_SVH
`define FLV_TAG_FRAMER_CORE_MACROS_SVH

// Same-cycle implication, skipped while reset is asserted.
`define FLVTF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, skipped while reset is asserted.
`define FLVTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked while reset is asserted.
`define FLVTF_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: unconditional implication");

`endif

@@ rtl/flvtf_pkg.sv @@
package flvtf_pkg;

  localparam int unsigned InDataW  = 112;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;
  localparam int unsigned PosW     = 5;

  localparam logic [CfgIdxW-1:0] CfgAudioPresent = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgVideoPresent = 1'b1;

  localparam logic [7:0] TypeAudio = 8'h08;
  localparam logic [7:0] TypeVideo = 8'h09;

  typedef enum logic [1:0] {
    OP_FILE_HDR  = 2'd0,
    OP_TAG_START = 2'd1,
    OP_PAYLOAD   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    JOB_FILE_HDR = 2'd0,
    JOB_TAG_HDR  = 2'd1,
    JOB_PAYLOAD  = 2'd2
  } job_kind_e;

  // Input beat payload, most significant member first.
  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  payload_byte;
    logic [23:0] payload_length;
    logic        is_sequence_header;
    logic        is_keyframe;
    logic [31:0] decode_time;
    logic [31:0] present_time;
    logic [7:0]  tag_type;
  } in_item_t;

  // One unit of output work handed from the front to the back.
  typedef struct packed {
    job_kind_e   kind;
    logic        video;
    logic        key;
    logic        seq;
    logic        trailer;
    logic        audio_flag;
    logic        video_flag;
    logic [23:0] size;
    logic [31:0] dts;
    logic [23:0] cto;
    logic [7:0]  pbyte;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ rtl/flvtf_queue.sv @@
module flvtf_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  flvtf_pkg::job_t         push_job_i,
  input  logic                    pop_i,
  output flvtf_pkg::job_t         head_job_o,
  output flvtf_pkg::queue_status_t status_o
);

  flvtf_pkg::job_t mem_q [2];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_job_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

endmodule

@@ rtl/flvtf_front.sv @@
module flvtf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [flvtf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [flvtf_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                accept_i,
  input  logic [flvtf_pkg::InUserW-1:0]       op_i,
  input  flvtf_pkg::in_item_t                 item_i,
  output logic                                push_o,
  output flvtf_pkg::job_t                     job_o
);

  logic        audio_q, video_q;
  logic [23:0] rem_q, rem_d;
  logic [23:0] size_q, size_d;
  logic        open_q, open_d;
  logic        vtype_q, vtype_d;
  logic        is_video, is_audio;
  logic [23:0] rem_dec;
  logic [23:0] new_size;

  assign is_video = (item_i.tag_type == flvtf_pkg::TypeVideo);
  assign is_audio = (item_i.tag_type == flvtf_pkg::TypeAudio);
  assign rem_dec  = rem_q - 24'd1;
  assign new_size = item_i.payload_length + (is_video ? 24'd5 : 24'd2);

  always_comb begin
    rem_d   = rem_q;
    size_d  = size_q;
    open_d  = open_q;
    vtype_d = vtype_q;
    push_o  = 1'b0;

    job_o            = '0;
    job_o.kind       = flvtf_pkg::JOB_PAYLOAD;
    job_o.video      = is_video;
    job_o.key        = item_i.is_keyframe;
    job_o.seq        = item_i.is_sequence_header;
    job_o.audio_flag = audio_q;
    job_o.video_flag = video_q;
    job_o.size       = size_q;
    job_o.dts        = item_i.decode_time;
    // The composition offset only needs the low 24 bits of the difference.
    job_o.cto        = item_i.is_sequence_header ? 24'd0 :
                       (item_i.present_time[23:0] - item_i.decode_time[23:0]);
    job_o.pbyte      = item_i.payload_byte;

    if (accept_i) begin
      case (flvtf_pkg::op_e'(op_i))
        flvtf_pkg::OP_FILE_HDR: begin
          open_d     = 1'b0;
          vtype_d    = 1'b0;
          rem_d      = 24'd0;
          push_o     = 1'b1;
          job_o.kind = flvtf_pkg::JOB_FILE_HDR;
        end
        flvtf_pkg::OP_TAG_START: begin
          vtype_d = is_video || is_audio;
          rem_d   = item_i.payload_length;
          open_d  = (item_i.payload_length != 24'd0);
          size_d  = (is_video || is_audio) ? new_size : 24'd0;
          if (is_video || is_audio) begin
            push_o        = 1'b1;
            job_o.kind    = flvtf_pkg::JOB_TAG_HDR;
            job_o.size    = new_size;
            job_o.trailer = (item_i.payload_length == 24'd0);
          end
        end
        flvtf_pkg::OP_PAYLOAD: begin
          if (open_q) begin
            rem_d         = rem_dec;
            push_o        = vtype_q;
            job_o.trailer = (rem_dec == 24'd0);
            if (rem_dec == 24'd0) begin
              open_d  = 1'b0;
              vtype_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_q <= 1'b0;
      video_q <= 1'b0;
      rem_q   <= 24'd0;
      size_q  <= 24'd0;
      open_q  <= 1'b0;
      vtype_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == flvtf_pkg::CfgAudioPresent) begin
        audio_q <= cfg_data_i[0];
      end
      if (cfg_we_i && cfg_idx_i == flvtf_pkg::CfgVideoPresent) begin
        video_q <= cfg_data_i[0];
      end
      rem_q   <= rem_d;
      size_q  <= size_d;
      open_q  <= open_d;
      vtype_q <= vtype_d;
    end
  end

endmodule

@@ rtl/flvtf_back.sv @@
module flvtf_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  flvtf_pkg::job_t                job_i,
  input  logic                           job_valid_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [flvtf_pkg::OutDataW-1:0] out_byte_o,
  output logic                           out_last_o,
  output logic                           out_eot_o
);

  logic [flvtf_pkg::PosW-1:0] pos_q, pos_d;
  logic [flvtf_pkg::PosW-1:0] body_len, total_len, tpos;
  logic [24:0] trl;
  logic [7:0]  byte_c;
  logic        last_c, eot_c, load;
  logic        ov_q;
  logic [7:0]  obyte_q;
  logic        olast_q, oeot_q;

  always_comb begin
    case (job_i.kind)
      flvtf_pkg::JOB_FILE_HDR: body_len = 5'd13;
      flvtf_pkg::JOB_TAG_HDR:  body_len = job_i.video ? 5'd16 : 5'd13;
      default:                 body_len = 5'd1;
    endcase
  end

  assign total_len = body_len + (job_i.trailer ? 5'd4 : 5'd0);
  assign tpos      = pos_q - body_len;
  // Previous-tag-size is data size plus the 11-byte tag header.
  assign trl       = {1'b0, job_i.size} + 25'd11;

  always_comb begin
    byte_c = 8'h00;
    eot_c  = 1'b0;
    if (pos_q >= body_len) begin
      case (tpos[1:0])
        2'd0:    byte_c = {7'b0, trl[24]};
        2'd1:    byte_c = trl[23:16];
        2'd2:    byte_c = trl[15:8];
        default: begin
          byte_c = trl[7:0];
          eot_c  = 1'b1;
        end
      endcase
    end else begin
      case (job_i.kind)
        flvtf_pkg::JOB_FILE_HDR: begin
          case (pos_q)
            5'd0:    byte_c = 8'h46;
            5'd1:    byte_c = 8'h4C;
            5'd2:    byte_c = 8'h56;
            5'd3:    byte_c = 8'h01;
            5'd4:    byte_c = {5'b0, job_i.audio_flag, 1'b0, job_i.video_flag};
            5'd8:    byte_c = 8'h09;
            5'd12: begin
              byte_c = 8'h00;
              eot_c  = 1'b1;
            end
            default: byte_c = 8'h00;
          endcase
        end
        flvtf_pkg::JOB_TAG_HDR: begin
          case (pos_q)
            5'd0:    byte_c = job_i.video ? flvtf_pkg::TypeVideo : flvtf_pkg::TypeAudio;
            5'd1:    byte_c = job_i.size[23:16];
            5'd2:    byte_c = job_i.size[15:8];
            5'd3:    byte_c = job_i.size[7:0];
            5'd4:    byte_c = job_i.dts[23:16];
            5'd5:    byte_c = job_i.dts[15:8];
            5'd6:    byte_c = job_i.dts[7:0];
            5'd7:    byte_c = job_i.dts[31:24];
            5'd11:   byte_c = job_i.video ? (job_i.key ? 8'h17 : 8'h27) : 8'hAF;
            5'd12:   byte_c = {7'b0, ~job_i.seq};
            5'd13:   byte_c = job_i.cto[23:16];
            5'd14:   byte_c = job_i.cto[15:8];
            5'd15:   byte_c = job_i.cto[7:0];
            default: byte_c = 8'h00;
          endcase
        end
        default: byte_c = job_i.pbyte;
      endcase
    end
  end

  assign last_c = (pos_q == total_len - 5'd1);
  assign load   = job_valid_i && (!ov_q || out_ready_i);
  assign pop_o  = load && last_c;
  assign pos_d  = load ? (last_c ? '0 : pos_q + 5'd1) : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= byte_c;
      olast_q <= last_c;
      oeot_q  <= eot_c;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign out_eot_o   = oeot_q;

endmodule

@@ rtl/flv_tag_framer_core.sv @@
// Channel   Dir  Beat contents
// s_axis    in   tuser: operation; tdata: tag and payload fields
// m_axis    out  tdata: stream byte; tlast: last of run; tuser: end of tag
// cfg       in   index 0 audio_present, index 1 video_present
//
// Payload beats stream at one byte per cycle unless the output stalls; on the
// output side a file header is 13 bytes and a tag header 13 or 16 bytes (plus
// 4 for an inline trailer), set by the byte serializer, which emits one byte
// per cycle unless stalled. A two-entry job queue parts the input from the
// serializer, so input beats flow until it fills. Async reset clears control state only.
module flv_tag_framer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, from bit 0: tag_type[7:0], present_time[39:8], decode_time[71:40],
  // is_keyframe[72], is_sequence_header[73], payload_length[97:74],
  // payload_byte[105:98], zero fill[111:106]
  input  logic [flvtf_pkg::InDataW-1:0]       s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [flvtf_pkg::InUserW-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: out_byte[7:0]
  output logic [flvtf_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast,
  // tuser: end_of_tag[0]
  output logic                                m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [flvtf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [flvtf_pkg::CfgDataW-1:0]      cfg_data_i
);

  flvtf_pkg::job_t          push_job, head_job;
  flvtf_pkg::queue_status_t q_status;
  logic                     push, pop, accept;

  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  flvtf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .op_i       (s_axis_tuser),
    .item_i     (flvtf_pkg::in_item_t'(s_axis_tdata)),
    .push_o     (push),
    .job_o      (push_job)
  );

  flvtf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_job_o (head_job),
    .status_o   (q_status)
  );

  flvtf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (!q_status.empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_eot_o   (m_axis_tuser)
  );

endmodule

@@ rtl/flvtf_checker.sv @@
`include "flv_tag_framer_core_macros.svh"

module flvtf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [flvtf_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                           m_axis_tlast,
  input logic                           m_axis_tuser
);

  logic                           out_stall;
  logic [flvtf_pkg::OutDataW+1:0] out_beat;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_beat  = {m_axis_tdata, m_axis_tlast, m_axis_tuser};

  // The end of a tag or file header always closes the run of its input beat.
  `FLVTF_ASSERT_IMPLY(a_eot_is_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

  // A stalled output beat stays put until taken.
  `FLVTF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_beat))

  // Once reset has been seen at an edge, nothing is offered on the output.
  `FLVTF_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni, !m_axis_tvalid)

  // After reset the job queue is empty, so the input side is open.
  `FLVTF_ASSERT_NEXT(a_ready_post_rst, clk_i, rst_ni, $rose(rst_ni), s_axis_tready || s_axis_tvalid)

endmodule

bind flv_tag_framer_core flvtf_checker u_flvtf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

@@ dv/tb.sv @@
module tb;
  import flvtf_pkg::*;

  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam logic [7:0]  FlvVersion  = 8'h01;
  localparam logic [7:0]  FileHdrSize = 8'h09;
  localparam logic [7:0]  FlagAudio   = 8'h04;
  localparam logic [7:0]  FlagVideo   = 8'h01;
  localparam logic [7:0]  AvcKeyFrame = 8'h17;
  localparam logic [7:0]  AvcInter    = 8'h27;
  localparam logic [7:0]  AacCodec    = 8'hAF;
  localparam logic [7:0]  PktConfig   = 8'h00;
  localparam logic [7:0]  PktData     = 8'h01;
  localparam logic [23:0] AvcExtra    = 24'd5;
  localparam logic [23:0] AacExtra    = 24'd2;
  localparam logic [31:0] TagHdrBytes = 32'd11;
  localparam int          RxHoldLen   = 300;
  localparam int          DrainCycles = 40;
  localparam int          MaxPrinted  = 100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eot;
  } flv_byte_t;

  class flv_stream_predictor;
    logic        audio_flag = 1'b0;
    logic        video_flag = 1'b0;
    logic [23:0] bytes_left = '0;
    logic [23:0] data_size  = '0;
    logic        tag_open   = 1'b0;
    logic        tag_shown  = 1'b0;
    flv_byte_t   expected_bytes[$];
    flv_byte_t   run[$];
    int          mismatches = 0;
    int          byte_idx   = 0;

    function void set_flag(logic [CfgIdxW-1:0] idx, logic val);
      if (idx == CfgAudioPresent) audio_flag = val;
      else video_flag = val;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void emit(logic [7:0] b, logic eot);
      flv_byte_t e;
      e.data = b;
      e.last = 1'b0;
      e.eot  = eot;
      run.push_back(e);
    endfunction

    function void emit_trailer();
      logic [31:0] t;
      t = {8'h00, data_size} + TagHdrBytes;
      emit(t[31:24], 1'b0);
      emit(t[23:16], 1'b0);
      emit(t[15:8], 1'b0);
      emit(t[7:0], 1'b1);
    endfunction

    // Works out the bytes one accepted input beat causes.
    function void note_item(logic [1:0] op, in_item_t it);
      logic        video;
      logic [31:0] cto;
      run.delete();
      case (op)
        OP_FILE_HDR: begin
          tag_open   = 1'b0;
          tag_shown  = 1'b0;
          bytes_left = '0;
          emit("F", 1'b0);
          emit("L", 1'b0);
          emit("V", 1'b0);
          emit(FlvVersion, 1'b0);
          emit((audio_flag ? FlagAudio : 8'h00) | (video_flag ? FlagVideo : 8'h00), 1'b0);
          emit(8'h00, 1'b0);
          emit(8'h00, 1'b0);
          emit(8'h00, 1'b0);
          emit(FileHdrSize, 1'b0);
          emit(8'h00, 1'b0);
          emit(8'h00, 1'b0);
          emit(8'h00, 1'b0);
          emit(8'h00, 1'b1);
        end
        OP_TAG_START: begin
          video      = (it.tag_type == TypeVideo);
          tag_shown  = video || (it.tag_type == TypeAudio);
          bytes_left = it.payload_length;
          tag_open   = (it.payload_length != 0);
          if (tag_shown) begin
            data_size = it.payload_length + (video ? AvcExtra : AacExtra);
            emit(it.tag_type, 1'b0);
            emit(data_size[23:16], 1'b0);
            emit(data_size[15:8], 1'b0);
            emit(data_size[7:0], 1'b0);
            // The timestamp's top byte goes out last, as the extended byte.
            emit(it.decode_time[23:16], 1'b0);
            emit(it.decode_time[15:8], 1'b0);
            emit(it.decode_time[7:0], 1'b0);
            emit(it.decode_time[31:24], 1'b0);
            emit(8'h00, 1'b0);
            emit(8'h00, 1'b0);
            emit(8'h00, 1'b0);
            if (video) begin
              cto = it.is_sequence_header ? 32'd0 : it.present_time - it.decode_time;
              emit(it.is_keyframe ? AvcKeyFrame : AvcInter, 1'b0);
              emit(it.is_sequence_header ? PktConfig : PktData, 1'b0);
              emit(cto[23:16], 1'b0);
              emit(cto[15:8], 1'b0);
              emit(cto[7:0], 1'b0);
            end else begin
              emit(AacCodec, 1'b0);
              emit(it.is_sequence_header ? PktConfig : PktData, 1'b0);
            end
            if (!tag_open) emit_trailer();
          end else begin
            data_size = '0;
          end
        end
        OP_PAYLOAD: begin
          if (tag_open) begin
            if (tag_shown) emit(it.payload_byte, 1'b0);
            bytes_left = bytes_left - 24'd1;
            if (bytes_left == 0) begin
              if (tag_shown) emit_trailer();
              tag_open  = 1'b0;
              tag_shown = 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (run.size() > 0) begin
        run[run.size()-1].last = 1'b1;
        foreach (run[i]) expected_bytes.push_back(run[i]);
      end
    endfunction

    task report_mismatch(string msg);
      // Keep the log readable when a broken block spews errors.
      if (mismatches < MaxPrinted) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_byte(logic [7:0] b, logic last, logic eot);
      flv_byte_t e;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %0d: got %h with nothing expected", byte_idx, b));
      end else begin
        e = expected_bytes.pop_front();
        if (b !== e.data)
          report_mismatch($sformatf("byte %0d: out_byte %h, want %h", byte_idx, b, e.data));
        if (last !== e.last)
          report_mismatch($sformatf("byte %0d: last_of_run %b, want %b", byte_idx, last,
                                    e.last));
        if (eot !== e.eot)
          report_mismatch($sformatf("byte %0d: end_of_tag %b, want %b", byte_idx, eot, e.eot));
      end
      byte_idx++;
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  flv_stream_predictor sb;
  int src_idle_pct = 0;
  int rx_stall_pct = 0;
  int beats_sent   = 0;
  logic rx_hold_req = 1'b0;
  int rx_hold_left  = 0;

  flv_tag_framer_core dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Input beats are noted before output beats are checked; each output byte is
  // registered behind the job queue, so it always finds its expectation noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(s_axis_tuser, in_item_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready)
        sb.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = RxHoldLen;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic in_item_t rand_item();
    in_item_t it;
    it.pad                = '0;
    it.payload_byte       = 8'($urandom);
    it.payload_length     = 24'($urandom);
    it.is_sequence_header = 1'($urandom);
    it.is_keyframe        = 1'($urandom);
    it.decode_time        = $urandom;
    it.present_time       = $urandom;
    it.tag_type           = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t tag_item(logic [7:0] kind, logic [23:0] len, logic [31:0] pts,
                                        logic [31:0] dts, logic key, logic seq);
    in_item_t it;
    it = rand_item();
    it.tag_type           = kind;
    it.payload_length     = len;
    it.present_time       = pts;
    it.decode_time        = dts;
    it.is_keyframe        = key;
    it.is_sequence_header = seq;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(logic [1:0] op, in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (op != OpUnused) beats_sent++;
  endtask

  task automatic send_payload(logic [7:0] b);
    in_item_t it;
    it = rand_item();
    it.payload_byte = b;
    send_beat(OP_PAYLOAD, it);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_flag(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    // Waiting out a falling edge with the write enable low keeps consecutive writes apart.
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic random_step();
    int r;
    int len;
    int n;
    logic [7:0] kind;
    in_item_t it;
    r = $urandom_range(99);
    if (r < 70) begin
      // Well-formed tag: header followed by exactly its payload.
      n = $urandom_range(99);
      kind = (n < 45) ? TypeVideo : (n < 85) ? TypeAudio : 8'($urandom);
      len = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(24, 7);
      send_beat(OP_TAG_START, tag_item(kind, 24'(len), $urandom, $urandom,
                                       1'($urandom_range(1)), 1'($urandom_range(1))));
      repeat (len) begin
        if ($urandom_range(99) < 3) send_beat(OpUnused, rand_item());
        send_beat(OP_PAYLOAD, rand_item());
      end
    end else if (r < 78) begin
      send_beat(OP_FILE_HDR, rand_item());
    end else if (r < 85) begin
      send_beat(OP_PAYLOAD, rand_item());
    end else if (r < 90) begin
      send_beat(OpUnused, rand_item());
    end else begin
      // Tag cut short; a later tag start or file header abandons it.
      it = rand_item();
      if ($urandom_range(3) != 0) it.tag_type = $urandom_range(1) ? TypeVideo : TypeAudio;
      if ($urandom_range(1) != 0) it.payload_length = 24'($urandom_range(30, 2));
      n = $urandom_range(5);
      if (it.payload_length <= n) n = (it.payload_length == 0) ? 0 : int'(it.payload_length) - 1;
      send_beat(OP_TAG_START, it);
      repeat (n) send_beat(OP_PAYLOAD, rand_item());
    end
  endtask

  initial begin
    int target;
    int mode;
    sb = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_reg(CfgAudioPresent, 1'b1);
    write_reg(CfgVideoPresent, 1'b1);

    send_beat(OP_PAYLOAD, rand_item());
    send_beat(OpUnused, rand_item());
    send_beat(OP_FILE_HDR, rand_item());
    send_beat(OP_TAG_START, tag_item(TypeVideo, 24'd1, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_payload(8'hFF);
    // Decode time after presentation time: the offset wraps.
    send_beat(OP_TAG_START, tag_item(TypeVideo, 24'd2, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0));
    send_payload(8'h00);
    send_payload(8'hFF);
    send_beat(OP_TAG_START, tag_item(TypeAudio, 24'd0, $urandom, $urandom, 1'b0, 1'b1));
    send_beat(OP_TAG_START, tag_item(TypeAudio, 24'd1, $urandom, $urandom, 1'b1, 1'b0));
    send_payload(8'h5A);
    send_beat(OP_TAG_START, tag_item(TypeVideo, 24'd0, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0));
    send_beat(OP_TAG_START, tag_item(8'h00, 24'd2, $urandom, $urandom, 1'b0, 1'b0));
    send_payload(8'h11);
    send_payload(8'h22);
    send_beat(OP_TAG_START, tag_item(8'hFF, 24'd0, $urandom, $urandom, 1'b1, 1'b1));
    send_payload(8'h33);
    // Full-scale lengths wrap the data size; each tag is abandoned by the next.
    send_beat(OP_TAG_START, tag_item(TypeVideo, 24'hFF_FFFF, $urandom, $urandom, 1'b0, 1'b0));
    send_payload(8'hA5);
    send_beat(OP_TAG_START, tag_item(TypeAudio, 24'hFF_FFFF, $urandom, $urandom, 1'b0, 1'b0));
    send_beat(OP_FILE_HDR, rand_item());
    send_beat(OP_TAG_START, tag_item(TypeVideo, 24'd16777210, $urandom, $urandom, 1'b1, 1'b0));
    send_beat(OP_TAG_START, tag_item(TypeAudio, 24'd3, $urandom, $urandom, 1'b0, 1'b0));
    repeat (3) send_beat(OP_PAYLOAD, rand_item());

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_reg(CfgAudioPresent, p[0]);
      write_reg(CfgVideoPresent, p[1]);
      mode = (p / 2) % 4;
      case (mode)
        0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin src_idle_pct = 87; rx_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  rx_stall_pct = 87; end
        default: begin src_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      // Hold the output off while the input keeps pushing, so the job queue fills.
      if (p == 0) rx_hold_req = 1'b1;
      target = beats_sent + 30;
      send_beat(OP_FILE_HDR, rand_item());
      while (beats_sent < target) random_step();
    end

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
